// ===== rtl/form_url_percent_decoder_top_assert.svh =====
// Assertion macros used by the decoder top
`ifndef FORM_URL_PERCENT_DECODER_TOP_ASSERT_SVH
`define FORM_URL_PERCENT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FUPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define FUPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fupd_pkg.sv =====
package fupd_pkg;

  // Characters the decoder reacts to
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;

  // Most decoded bytes one raw byte can release
  localparam int unsigned MaxOut = 3;

  // Escape tracking phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  // Group of decoded bytes released by one raw byte
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [1:0]             cnt;
    logic                   last;
  } pkt_t;

  // Hex digit check
  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Nibble value of a hex digit (zero for anything else)
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/fupd_front.sv =====
module fupd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output logic              push_o,
  output fupd_pkg::pkt_t    pkt_o,
  output logic              pend_o
);

  fupd_pkg::phase_e phase_q, phase_d, phase_mid;
  logic [7:0]       held_q, held_d;
  logic             hex;
  logic [7:0]       mapped;

  assign hex    = fupd_pkg::is_hex(byte_i);
  assign mapped = (byte_i == fupd_pkg::ChPlus) ? fupd_pkg::ChSpace : byte_i;
  assign pend_o = (phase_q != fupd_pkg::PH_IDLE);

  // Next phase and held digit
  always_comb begin
    phase_mid = (byte_i == fupd_pkg::ChPercent) ? fupd_pkg::PH_PCT : fupd_pkg::PH_IDLE;
    held_d    = 8'h00;
    unique case (phase_q)
      fupd_pkg::PH_PCT: begin
        if (hex) begin
          phase_mid = fupd_pkg::PH_DIGIT;
          held_d    = byte_i;
        end
      end
      fupd_pkg::PH_DIGIT: begin
        if (hex) begin
          phase_mid = fupd_pkg::PH_IDLE;
        end
      end
      default: begin
      end
    endcase
    phase_d = last_i ? fupd_pkg::PH_IDLE : phase_mid;
    if (last_i) begin
      held_d = 8'h00;
    end
  end

  // Released bytes for this raw byte
  always_comb begin
    logic [1:0] n;
    logic       idle;
    n     = 2'd0;
    idle  = 1'b0;
    pkt_o = '0;
    unique case (phase_q)
      fupd_pkg::PH_PCT: begin
        if (!hex) begin
          pkt_o.bytes[n] = fupd_pkg::ChPercent;
          n              = n + 2'd1;
          idle           = 1'b1;
        end
      end
      fupd_pkg::PH_DIGIT: begin
        if (hex) begin
          pkt_o.bytes[n] = {fupd_pkg::hex_nibble(held_q), fupd_pkg::hex_nibble(byte_i)};
          n              = n + 2'd1;
        end else begin
          pkt_o.bytes[n] = fupd_pkg::ChPercent;
          n              = n + 2'd1;
          pkt_o.bytes[n] = held_q;
          n              = n + 2'd1;
          idle           = 1'b1;
        end
      end
      default: begin
        idle = 1'b1;
      end
    endcase
    // Plain or plus byte from the idle phase
    if (idle && byte_i != fupd_pkg::ChPercent) begin
      pkt_o.bytes[n] = mapped;
      n              = n + 2'd1;
    end
    // Flush an incomplete sequence at end of string
    if (last_i) begin
      if (phase_mid == fupd_pkg::PH_PCT) begin
        pkt_o.bytes[n] = fupd_pkg::ChPercent;
        n              = n + 2'd1;
      end else if (phase_mid == fupd_pkg::PH_DIGIT) begin
        pkt_o.bytes[n] = fupd_pkg::ChPercent;
        n              = n + 2'd1;
        pkt_o.bytes[n] = byte_i;
        n              = n + 2'd1;
      end
    end
    pkt_o.cnt  = n;
    pkt_o.last = last_i;
  end

  assign push_o = accept_i && (pkt_o.cnt != 2'd0);

  // Advance escape state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fupd_pkg::PH_IDLE;
      held_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== rtl/fupd_queue.sv =====
module fupd_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fupd_pkg::pkt_t pkt_i,
  input  logic           pop_i,
  output fupd_pkg::pkt_t pkt_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  fupd_pkg::pkt_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntFull);
  assign pkt_o   = mem_q[rd_q];

  // Store request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/fupd_back.sv =====
module fupd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fupd_pkg::pkt_t pkt_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load, final_byte;

  assign load       = !empty_i && (!valid_q || out_ready_i);
  assign final_byte = (idx_q == pkt_i.cnt - 2'd1);
  assign pop_o      = load && final_byte;

  // Step through the bytes of the head request
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = final_byte ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Load output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= pkt_i.bytes[idx_q];
      last_q <= pkt_i.last && final_byte;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

// ===== rtl/form_url_percent_decoder_top.sv =====
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o  in_byte_i, in_last_i
// out      out_valid_o / out_ready_i out_byte_o, out_last_o
//
// One raw byte is taken per cycle while the request queue has room.
// Each raw byte releases zero to three decoded bytes; the output stage sends
// one decoded byte per cycle while a request is queued and the receiver is ready.
// The path from input to output runs through the queue write and the output register.
// Reset clears the escape phase, the queue and the output valid.
// Either side may stall; the queue of QueueDepth requests decouples them.
module form_url_percent_decoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  `include "form_url_percent_decoder_top_assert.svh"

  fupd_pkg::pkt_t push_pkt, head_pkt;
  logic           accept, push, pop, q_empty, q_full, pend;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  fupd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_byte_i),
    .last_i   (in_last_i),
    .push_o   (push),
    .pkt_o    (push_pkt),
    .pend_o   (pend)
  );

  fupd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (push_pkt),
    .pop_i   (pop),
    .pkt_o   (head_pkt),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  fupd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (head_pkt),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  // Queue bookkeeping and end-of-string flush
  `FUPD_ASSERT_SAME(a_no_overflow, push, !q_full, "push into full queue")
  `FUPD_ASSERT_SAME(a_no_underflow, pop, !q_empty, "pop from empty queue")
  `FUPD_ASSERT_SAME(a_last_emits, accept && in_last_i, push, "string end released no byte")
  `FUPD_ASSERT_NEXT(a_last_flushes, accept && in_last_i, !pend, "escape pending after end")

endmodule
